### rtl/bsfe_pkg.sv
`default_nettype none
package bsfe_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned ActW = 2;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned QueuePtrW = $clog2(QueueDepth);
	localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

	localparam logic [ActW-1:0] ACT_START = 2'd0;
	localparam logic [ActW-1:0] ACT_DATA  = 2'd1;
	localparam logic [ActW-1:0] ACT_END   = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_START_BYTE  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_END_BYTE    = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_ESCAPE_BYTE = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_SKIP_START  = 2'd3;

	localparam logic [ByteW-1:0] START_BYTE_RST  = 8'd2;
	localparam logic [ByteW-1:0] END_BYTE_RST    = 8'd3;
	localparam logic [ByteW-1:0] ESCAPE_BYTE_RST = 8'd27;

	// one classified item: up to two result bytes
	typedef struct packed {
		logic             two;
		logic             byte_valid;
		logic             error;
		logic [ByteW-1:0] b0;
		logic [ByteW-1:0] b1;
	} entry_t;

	typedef struct packed {
		logic push;
		logic full;
	} push_ctl_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} pop_ctl_t;

endpackage
`default_nettype wire

### rtl/bsfe_front.sv
`default_nettype none
module bsfe_front
	import bsfe_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [ByteW-1:0]    cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [ActW-1:0]     action,
	input  wire logic [ByteW-1:0]    data_byte,
	input  wire logic                queue_full,
	output push_ctl_t                push_ctl,
	output entry_t                   entry
);

	logic [ByteW-1:0] start_byte_q;
	logic [ByteW-1:0] end_byte_q;
	logic [ByteW-1:0] escape_byte_q;
	logic             skip_start_q;
	logic             in_frame_q;
	logic             accept;
	logic             special;
	logic             in_frame_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = !queue_full;
	assign accept    = in_valid && !queue_full;

	assign push_ctl.push = accept;
	assign push_ctl.full = queue_full;

	assign special = (data_byte == start_byte_q) || (data_byte == end_byte_q) ||
		(data_byte == escape_byte_q);

	always_comb begin
		entry      = '0;
		in_frame_d = in_frame_q;
		case (action)
			ACT_START: begin
				in_frame_d = 1'b1;
				if (in_frame_q) begin
					entry.byte_valid = 1'b1;
					entry.b0         = end_byte_q;
					entry.b1         = start_byte_q;
					entry.two        = !skip_start_q;
				end else if (!skip_start_q) begin
					entry.byte_valid = 1'b1;
					entry.b0         = start_byte_q;
				end
			end
			ACT_DATA: begin
				if (!in_frame_q) begin
					entry.error = 1'b1;
				end else if (special) begin
					entry.byte_valid = 1'b1;
					entry.two        = 1'b1;
					entry.b0         = escape_byte_q;
					entry.b1         = data_byte;
				end else begin
					entry.byte_valid = 1'b1;
					entry.b0         = data_byte;
				end
			end
			ACT_END: begin
				if (!in_frame_q) begin
					entry.error = 1'b1;
				end else begin
					entry.byte_valid = 1'b1;
					entry.b0         = end_byte_q;
					in_frame_d       = 1'b0;
				end
			end
			default: begin
				// unused code: status-only result
				entry = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= START_BYTE_RST;
			end_byte_q    <= END_BYTE_RST;
			escape_byte_q <= ESCAPE_BYTE_RST;
			skip_start_q  <= 1'b0;
			in_frame_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_START_BYTE:  start_byte_q  <= cfg_data;
					REG_END_BYTE:    end_byte_q    <= cfg_data;
					REG_ESCAPE_BYTE: escape_byte_q <= cfg_data;
					REG_SKIP_START:  skip_start_q  <= cfg_data[0];
					default:         skip_start_q  <= skip_start_q;
				endcase
			end
			if (accept) begin
				in_frame_q <= in_frame_d;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/bsfe_queue.sv
`default_nettype none
module bsfe_queue
	import bsfe_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire push_ctl_t push_ctl,
	input  wire entry_t    wr_entry,
	output logic           full,
	input  wire logic      pop,
	output pop_ctl_t       pop_ctl,
	output entry_t         rd_entry
);

	entry_t                mem_q [QueueDepth];
	logic [QueuePtrW-1:0]  wr_ptr_q;
	logic [QueuePtrW-1:0]  rd_ptr_q;
	logic [QueueCntW-1:0]  count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full          = (count_q == QueueCntW'(QueueDepth));
	assign pop_ctl.empty = (count_q == '0);
	assign pop_ctl.pop   = do_pop;
	assign do_push       = push_ctl.push && !full;
	assign do_pop        = pop && !pop_ctl.empty;
	assign rd_entry      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/bsfe_back.sv
`default_nettype none
module bsfe_back
	import bsfe_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire entry_t           entry,
	input  wire pop_ctl_t         pop_ctl,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [ByteW-1:0]      out_byte,
	output logic                  byte_valid,
	output logic                  error,
	output logic                  is_last
);

	logic             out_valid_q;
	logic [ByteW-1:0] out_byte_q;
	logic             byte_valid_q;
	logic             error_q;
	logic             is_last_q;
	logic             second_q;  // first byte of a two-byte entry already sent
	logic             load;

	assign load = (!out_valid_q || out_ready) && !pop_ctl.empty;
	assign pop  = load && (second_q || !entry.two);

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign error      = error_q;
	assign is_last    = is_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= second_q ? entry.b1 : entry.b0;
			byte_valid_q <= entry.byte_valid;
			error_q      <= entry.error;
			is_last_q    <= second_q || !entry.two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				second_q    <= !second_q && entry.two;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/byte_stuffing_frame_encoder.sv
// Byte-stuffing frame encoder. Each input item is a frame command in tuser
// (0 start, 1 data, 2 end) with the payload byte in tdata; each result carries one
// link byte in tdata, byte_valid and error in tuser, and tlast on the final result
// of its item. Data bytes equal to the start, end or escape byte go out behind an
// escape byte. The output sends one result per cycle while m_axis_tready is high
// and a result waits; an item yields two results for escaped data or for a start
// that closes an open frame with start bytes not skipped, else one. A two-entry
// queue sits between the classifier and the output register, so input is taken
// every cycle the queue has room, also while the output is stalled. Configuration
// writes are always ready and are meant to happen while idle.
`default_nettype none
module byte_stuffing_frame_encoder
	import bsfe_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [ByteW-1:0]    cfg_data,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [ByteW-1:0]    s_axis_tdata,  // [7:0] data_byte
	input  wire logic [ActW-1:0]     s_axis_tuser,  // [1:0] action
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [ByteW-1:0]         m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]               m_axis_tuser,  // [0] byte_valid, [1] error
	output logic                     m_axis_tlast
);

	push_ctl_t push_ctl;
	pop_ctl_t  pop_ctl;
	entry_t    wr_entry;
	entry_t    rd_entry;
	logic      queue_full;
	logic      pop;

	bsfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.action     (s_axis_tuser),
		.data_byte  (s_axis_tdata),
		.queue_full (queue_full),
		.push_ctl   (push_ctl),
		.entry      (wr_entry)
	);

	bsfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_ctl (push_ctl),
		.wr_entry (wr_entry),
		.full     (queue_full),
		.pop      (pop),
		.pop_ctl  (pop_ctl),
		.rd_entry (rd_entry)
	);

	bsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry      (rd_entry),
		.pop_ctl    (pop_ctl),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.byte_valid (m_axis_tuser[0]),
		.error      (m_axis_tuser[1]),
		.is_last    (m_axis_tlast)
	);

endmodule
`default_nettype wire

### rtl/bsfe_checker.sv
`default_nettype none
module bsfe_checker
	import bsfe_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             m_axis_tvalid,
	input  wire logic             m_axis_tready,
	input  wire logic [ByteW-1:0] m_axis_tdata,
	input  wire logic [1:0]       m_axis_tuser,
	input  wire logic             m_axis_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("stalled result changed");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("status-only result carries a byte");

	a_error_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tlast)
		else $error("error result not a single status-only result");

	// a first-of-two result is always a byte and followed by the closing byte
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid && m_axis_tlast && m_axis_tuser[0] && $past(m_axis_tuser[0]))
		else $error("two-byte item broken");

endmodule

bind byte_stuffing_frame_encoder bsfe_checker u_bsfe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
